>>> rtl/core/baro_sensor_compensation_core_macros.svh
// ----------------------------------------------------------------------------
// baro sensor compensation core assertion macros
// shared concurrent assertion shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef BARO_SENSOR_COMPENSATION_CORE_MACROS_SVH
`define BARO_SENSOR_COMPENSATION_CORE_MACROS_SVH

// checked only outside reset
`define BSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// shared widths, register codes and coefficient bundle
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  localparam int SCALED_FRAC_BITS = 24;

  localparam int RAW_W     = 24;
  localparam int SCALE_W   = 24;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int PRES_W    = 32;
  localparam int TEMP_W    = 24;

  // scaled reading: SCALED_FRAC_BITS+6 magnitude bits plus sign
  localparam int QB  = SCALED_FRAC_BITS + 6;
  localparam int QW  = QB + 1;
  // inner polynomial terms
  localparam int AW  = SCALED_FRAC_BITS + 23;
  localparam int ALO = (AW + 1) / 2;
  localparam int AHI = AW - ALO;
  localparam int BW  = 2 * SCALED_FRAC_BITS + 30;
  localparam int BC  = (BW + 3) / 4;
  localparam int BTOP = BW - 3 * BC;
  localparam int NW  = 3 * SCALED_FRAC_BITS + 38;
  localparam int TNW = SCALED_FRAC_BITS + 20;
  localparam int PSH = 3 * SCALED_FRAC_BITS - 6;
  localparam int TSH = SCALED_FRAC_BITS - 7;

  localparam int DIV_LAT  = SCALED_FRAC_BITS + 8;
  localparam int POLY_LAT = 11;
  localparam int TOT_LAT  = DIV_LAT + POLY_LAT;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(524288);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_COEFS   = 3'd0,
    CFG_PRES_OFS_LIN = 3'd1,
    CFG_PRES_CROSS   = 3'd2,
    CFG_PRES_CUBIC   = 3'd3,
    CFG_TEMP_SCALE   = 3'd4,
    CFG_PRES_SCALE   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [11:0] c0;
    logic signed [11:0] c1;
    logic signed [19:0] c00;
    logic signed [19:0] c10;
    logic signed [15:0] c01;
    logic signed [15:0] c11;
    logic signed [15:0] c20;
    logic signed [15:0] c21;
    logic signed [15:0] c30;
  } coef_t;

endpackage

`default_nettype wire

>>> rtl/core/bsc_div.sv
// ----------------------------------------------------------------------------
// bsc_div
// pipelined restoring divider: raw reading to signed scaled fixed point
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_div
  import bsc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [RAW_W-1:0]  raw,
  input  wire logic [SCALE_W-1:0]       scale,
  output logic signed [QW-1:0]          scaled
);

  logic [RAW_W-1:0]   mag;
  logic               ovf;

  logic [SCALE_W-1:0] rem_r [0:QB];
  logic [QB-1:0]      q_r   [0:QB];
  logic [5:0]         lo_r  [0:QB];
  logic               neg_r [0:QB];
  logic               ovf_r [0:QB];
  logic signed [QW-1:0] scaled_r;
  logic [QB-1:0]      mq;

  assign mag = raw[RAW_W-1] ? RAW_W'(-raw) : RAW_W'(raw);
  // quotient exceeds the magnitude limit exactly when mag >= scale * 64
  assign ovf = (RAW_W + 6)'(mag) >= {scale, 6'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= SCALE_W'(mag[RAW_W-1:6]);
      lo_r[0]  <= mag[5:0];
      q_r[0]   <= '0;
      neg_r[0] <= raw[RAW_W-1];
      ovf_r[0] <= ovf;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_step
    logic [SCALE_W:0] shifted;
    logic [SCALE_W:0] trial;
    assign shifted = {rem_r[i], lo_r[i][5]};
    assign trial   = shifted - {1'b0, scale};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= trial[SCALE_W] ? shifted[SCALE_W-1:0] : trial[SCALE_W-1:0];
        q_r[i+1]   <= {q_r[i][QB-2:0], ~trial[SCALE_W]};
        lo_r[i+1]  <= {lo_r[i][4:0], 1'b0};
        neg_r[i+1] <= neg_r[i];
        ovf_r[i+1] <= ovf_r[i];
      end
    end
  end

  assign mq = ovf_r[QB] ? {QB{1'b1}} : q_r[QB];

  always_ff @(posedge clk) begin
    if (en) begin
      scaled_r <= neg_r[QB] ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
    end
  end

  assign scaled = scaled_r;

endmodule

`default_nettype wire

>>> rtl/core/bsc_poly.sv
// ----------------------------------------------------------------------------
// bsc_poly
// pipelined compensation polynomials with split wide multiplies
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_poly
  import bsc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [QW-1:0]    p,
  input  wire logic signed [QW-1:0]    t,
  input  wire coef_t                   coef,
  output logic signed [PRES_W-1:0]     pressure_comp,
  output logic signed [TEMP_W-1:0]     temperature_comp
);

  // carried readings, index is the stage number
  logic signed [QW-1:0] p_r [1:5];
  logic signed [QW-1:0] t_r [1:5];

  logic signed [QW+15:0]   pa1_r, pc1_r;
  logic signed [TNW-1:0]   tm1_r;
  logic signed [AW-1:0]    a2_r, c2_r;
  logic signed [TNW-1:0]   tn2_r;
  logic signed [QW+ALO:0]  palo3_r, pclo3_r;
  logic signed [QW+AHI-1:0] pahi3_r, pchi3_r;
  logic signed [BW-1:0]    sb4_r, sd4_r;
  logic signed [BW-1:0]    b5_r, d5_r;
  logic signed [QW+BC:0]   pbl6_r [0:2];
  logic signed [QW+BC:0]   tdl6_r [0:2];
  logic signed [QW+BTOP-1:0] pbh6_r, tdh6_r;
  logic signed [NW-1:0]    pb01_r, pb23_r, td01_r, td23_r;
  logic signed [NW-1:0]    pb8_r, td8_r;
  logic signed [NW-1:0]    u9_r, n10_r;
  logic signed [PRES_W-1:0] pres_r;
  logic signed [TEMP_W-1:0] tq_r [0:8];

  logic signed [TNW-1:0]   tsh;
  logic signed [TEMP_W-1:0] tsat;
  logic signed [NW-1:0]    psh;
  logic signed [PRES_W-1:0] psat;

  // temperature: floor shift to 1/256 degC, then clamp
  assign tsh  = tn2_r >>> TSH;
  assign tsat = (&tsh[TNW-1:TEMP_W-1] || ~|tsh[TNW-1:TEMP_W-1]) ? tsh[TEMP_W-1:0] :
                (tsh[TNW-1] ? {1'b1, {(TEMP_W-1){1'b0}}} : {1'b0, {(TEMP_W-1){1'b1}}});

  // pressure: floor shift to 1/64 Pa, then clamp
  assign psh  = n10_r >>> PSH;
  assign psat = (&psh[NW-1:PRES_W-1] || ~|psh[NW-1:PRES_W-1]) ? psh[PRES_W-1:0] :
                (psh[NW-1] ? {1'b1, {(PRES_W-1){1'b0}}} : {1'b0, {(PRES_W-1){1'b1}}});

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[1] <= p;
      t_r[1] <= t;
      for (int k = 2; k <= 5; k++) begin
        p_r[k] <= p_r[k-1];
        t_r[k] <= t_r[k-1];
      end

      // stage 1: narrow products
      pa1_r <= p * $signed(coef.c30);
      pc1_r <= p * $signed(coef.c21);
      tm1_r <= t * $signed({coef.c1, 1'b0});

      // stage 2: inner sums
      a2_r  <= (AW'($signed(coef.c20)) <<< SCALED_FRAC_BITS) + AW'(pa1_r);
      c2_r  <= (AW'($signed(coef.c11)) <<< SCALED_FRAC_BITS) + AW'(pc1_r);
      tn2_r <= (TNW'($signed(coef.c0)) <<< SCALED_FRAC_BITS) + tm1_r;

      // stage 3: P times inner sums, two halves each
      palo3_r <= p_r[2] * $signed({1'b0, a2_r[ALO-1:0]});
      pahi3_r <= p_r[2] * $signed(a2_r[AW-1:ALO]);
      pclo3_r <= p_r[2] * $signed({1'b0, c2_r[ALO-1:0]});
      pchi3_r <= p_r[2] * $signed(c2_r[AW-1:ALO]);
      tq_r[0] <= tsat;
      for (int k = 1; k <= 8; k++) begin
        tq_r[k] <= tq_r[k-1];
      end

      // stage 4: merge halves
      sb4_r <= BW'(palo3_r) + (BW'(pahi3_r) <<< ALO);
      sd4_r <= BW'(pclo3_r) + (BW'(pchi3_r) <<< ALO);

      // stage 5: add the S^2 terms
      b5_r <= sb4_r + (BW'($signed(coef.c10)) <<< (2 * SCALED_FRAC_BITS));
      d5_r <= sd4_r + (BW'($signed(coef.c01)) <<< (2 * SCALED_FRAC_BITS));

      // stage 6: outer products, four chunks each
      for (int j = 0; j < 3; j++) begin
        pbl6_r[j] <= p_r[5] * $signed({1'b0, b5_r[j*BC +: BC]});
        tdl6_r[j] <= t_r[5] * $signed({1'b0, d5_r[j*BC +: BC]});
      end
      pbh6_r <= p_r[5] * $signed(b5_r[BW-1:3*BC]);
      tdh6_r <= t_r[5] * $signed(d5_r[BW-1:3*BC]);

      // stage 7: pairwise merge
      pb01_r <= NW'(pbl6_r[0]) + (NW'(pbl6_r[1]) <<< BC);
      pb23_r <= NW'(pbl6_r[2]) + (NW'(pbh6_r) <<< BC);
      td01_r <= NW'(tdl6_r[0]) + (NW'(tdl6_r[1]) <<< BC);
      td23_r <= NW'(tdl6_r[2]) + (NW'(tdh6_r) <<< BC);

      // stage 8
      pb8_r <= pb01_r + (pb23_r <<< (2 * BC));
      td8_r <= td01_r + (td23_r <<< (2 * BC));

      // stage 9
      u9_r <= pb8_r + td8_r;

      // stage 10: offset term
      n10_r <= u9_r + (NW'($signed(coef.c00)) <<< (3 * SCALED_FRAC_BITS));

      // stage 11: output
      pres_r <= psat;
    end
  end

  assign pressure_comp    = pres_r;
  assign temperature_comp = tq_r[8];

endmodule

`default_nettype wire

>>> rtl/core/baro_sensor_compensation_core.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation_core
// barometric sensor polynomial compensation, fully pipelined
// ----------------------------------------------------------------------------
// Accepts one raw pressure/temperature pair per clock while the output is
// not stalled, and returns the compensated pressure (1/64 Pa) and
// temperature (1/256 degC). The pipeline is made of the two restoring
// dividers, which resolve one quotient bit per stage over 30 stages plus
// an entry and a sign stage, followed by the 11-stage polynomial pipeline
// whose wide products are split into partial multiplies of at most 31 by
// 25 bits. The whole
// pipeline advances together; when a result waits on out_ready every stage
// holds, so in_ready drops only while the output register is full and not
// taken. Coefficient and scale registers must only be written while no
// transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_sensor_compensation_core
  import bsc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,

  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [RAW_W-1:0]  in_pressure_raw,
  input  wire logic signed [RAW_W-1:0]  in_temperature_raw,

  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [PRES_W-1:0]      out_pressure_comp,
  output logic signed [TEMP_W-1:0]      out_temperature_comp,

  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_wdata
);

  // configuration registers
  logic [23:0]        temp_coefs_r;
  logic [39:0]        pres_ofs_lin_r;
  logic [63:0]        pres_cross_r;
  logic [15:0]        pres_cubic_r;
  logic [SCALE_W-1:0] temp_scale_r;
  logic [SCALE_W-1:0] pres_scale_r;

  // valid bit per pipeline stage
  logic [TOT_LAT-1:0] vld_r;
  logic               en;

  coef_t               coef;
  logic signed [QW-1:0] p_scaled;
  logic signed [QW-1:0] t_scaled;

  // global advance: move when the output slot is empty or being taken
  assign en       = !vld_r[TOT_LAT-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[TOT_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT_LAT-2:0], in_valid};
    end
  end

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coefs_r   <= '0;
      pres_ofs_lin_r <= '0;
      pres_cross_r   <= '0;
      pres_cubic_r   <= '0;
      temp_scale_r   <= SCALE_RESET;
      pres_scale_r   <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEMP_COEFS:   temp_coefs_r   <= cfg_wdata[23:0];
        CFG_PRES_OFS_LIN: pres_ofs_lin_r <= cfg_wdata[39:0];
        CFG_PRES_CROSS:   pres_cross_r   <= cfg_wdata;
        CFG_PRES_CUBIC:   pres_cubic_r   <= cfg_wdata[15:0];
        CFG_TEMP_SCALE:   temp_scale_r   <= cfg_wdata[SCALE_W-1:0];
        CFG_PRES_SCALE:   pres_scale_r   <= cfg_wdata[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // unpack coefficient fields
  always_comb begin
    coef.c0  = temp_coefs_r[23:12];
    coef.c1  = temp_coefs_r[11:0];
    coef.c00 = pres_ofs_lin_r[39:20];
    coef.c10 = pres_ofs_lin_r[19:0];
    coef.c01 = pres_cross_r[63:48];
    coef.c11 = pres_cross_r[47:32];
    coef.c20 = pres_cross_r[31:16];
    coef.c21 = pres_cross_r[15:0];
    coef.c30 = pres_cubic_r;
  end

  // raw readings to scaled fixed point
  bsc_div u_div_pres (
    .clk    (clk),
    .en     (en),
    .raw    (in_pressure_raw),
    .scale  (pres_scale_r),
    .scaled (p_scaled)
  );

  bsc_div u_div_temp (
    .clk    (clk),
    .en     (en),
    .raw    (in_temperature_raw),
    .scale  (temp_scale_r),
    .scaled (t_scaled)
  );

  // polynomial evaluation, output register at its last stage
  bsc_poly u_poly (
    .clk              (clk),
    .en               (en),
    .p                (p_scaled),
    .t                (t_scaled),
    .coef             (coef),
    .pressure_comp    (out_pressure_comp),
    .temperature_comp (out_temperature_comp)
  );

endmodule

`default_nettype wire

>>> rtl/core/bsc_checker.sv
// ----------------------------------------------------------------------------
// bsc_checker
// port-level assertions for the compensation core
// ----------------------------------------------------------------------------
`default_nettype none

`include "baro_sensor_compensation_core_macros.svh"

module bsc_checker
  import bsc_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [PRES_W-1:0] out_pressure_comp,
  input wire logic signed [TEMP_W-1:0] out_temperature_comp
);

  // a held result keeps its payload
  `BSC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_pressure_comp) && $stable(out_temperature_comp), "result changed while stalled")

  // the pipeline empties on reset
  `BSC_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")

  // input side stalls only behind an untaken result
  `BSC_ASSERT(a_ready_link, in_ready == (out_ready || !out_valid), "input ready not tied to output slot")

  // nothing fed in during reset cannot surface right after it
  `BSC_ASSERT(a_no_early, $past(!rst_n) && !in_valid |=> !out_valid, "result appeared too early")

endmodule

bind baro_sensor_compensation_core bsc_checker u_bsc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_pressure_comp    (out_pressure_comp),
  .out_temperature_comp (out_temperature_comp)
);

`default_nettype wire

>>> sim/baro_sensor_compensation_scoreboard.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation_scoreboard
// watches the core's channels, predicts each compensated pair, compares
// ----------------------------------------------------------------------------
`default_nettype none

module baro_sensor_compensation_scoreboard
  import bsc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic                    in_ready,
  input  wire logic signed [RAW_W-1:0] in_pressure_raw,
  input  wire logic signed [RAW_W-1:0] in_temperature_raw,
  input  wire logic                    out_valid,
  input  wire logic                    out_ready,
  input  wire logic signed [PRES_W-1:0] out_pressure_comp,
  input  wire logic signed [TEMP_W-1:0] out_temperature_comp,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_wdata,
  output int                           errors,
  output int                           pending
);

  typedef logic signed [159:0] wide_t;

  typedef struct packed {
    logic signed [PRES_W-1:0] pres;
    logic signed [TEMP_W-1:0] temp;
  } comp_pair_t;

  logic [23:0] temp_coefs;
  logic [39:0] pres_ofs_lin;
  logic [63:0] pres_cross;
  logic [15:0] pres_cubic;
  logic [23:0] temp_scale;
  logic [23:0] pres_scale;

  comp_pair_t expected_pairs[$];

  // reading / scale, truncated toward zero, limited to six integer bits
  function automatic wide_t scale_reading(logic [23:0] raw, logic [23:0] sc);
    logic [63:0] mag;
    logic [63:0] quot;
    logic [63:0] lim;
    lim = (64'd1 << (SCALED_FRAC_BITS + 6)) - 1;
    mag = raw[23] ? (64'h1000000 - {40'd0, raw}) : {40'd0, raw};
    quot = (sc == 0) ? '1 : (mag << SCALED_FRAC_BITS) / sc;
    if (quot > lim) quot = lim;
    scale_reading = raw[23] ? -wide_t'(quot) : wide_t'(quot);
  endfunction

  function automatic comp_pair_t compensate(logic [23:0] praw, logic [23:0] traw);
    wide_t c0, c1, c00, c10, c01, c11, c20, c21, c30;
    wide_t p, t, s, s2, a, b, c, d, n, tn;
    comp_pair_t r;
    c0  = $signed(temp_coefs[23:12]);
    c1  = $signed(temp_coefs[11:0]);
    c00 = $signed(pres_ofs_lin[39:20]);
    c10 = $signed(pres_ofs_lin[19:0]);
    c01 = $signed(pres_cross[63:48]);
    c11 = $signed(pres_cross[47:32]);
    c20 = $signed(pres_cross[31:16]);
    c21 = $signed(pres_cross[15:0]);
    c30 = $signed(pres_cubic);
    p = scale_reading(praw, pres_scale);
    t = scale_reading(traw, temp_scale);
    s  = wide_t'(1) <<< SCALED_FRAC_BITS;
    s2 = s * s;
    // numerator in units of 2^-(3F)
    a = c20 * s + p * c30;
    b = c10 * s2 + p * a;
    c = c11 * s + p * c21;
    d = c01 * s2 + p * c;
    n = c00 * s2 * s + p * b + t * d;
    n = n >>> (3 * SCALED_FRAC_BITS - 6);
    if (n > wide_t'(32'sh7fffffff)) r.pres = 32'sh7fffffff;
    else if (n < -wide_t'(64'sh80000000)) r.pres = 32'sh80000000;
    else r.pres = n[31:0];
    // temperature in units of 2^-(F+1)
    tn = c0 * s + 2 * c1 * t;
    tn = tn >>> (SCALED_FRAC_BITS - 7);
    if (tn > wide_t'(24'sh7fffff)) r.temp = 24'sh7fffff;
    else if (tn < -wide_t'(64'sh800000)) r.temp = 24'sh800000;
    else r.temp = tn[23:0];
    compensate = r;
  endfunction

  assign pending = expected_pairs.size();

  always @(posedge clk) begin
    comp_pair_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      temp_coefs   <= '0;
      pres_ofs_lin <= '0;
      pres_cross   <= '0;
      pres_cubic   <= '0;
      temp_scale   <= SCALE_RESET;
      pres_scale   <= SCALE_RESET;
      errors       <= 0;
      expected_pairs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TEMP_COEFS:   temp_coefs   <= cfg_wdata[23:0];
          CFG_PRES_OFS_LIN: pres_ofs_lin <= cfg_wdata[39:0];
          CFG_PRES_CROSS:   pres_cross   <= cfg_wdata;
          CFG_PRES_CUBIC:   pres_cubic   <= cfg_wdata[15:0];
          CFG_TEMP_SCALE:   temp_scale   <= cfg_wdata[23:0];
          CFG_PRES_SCALE:   pres_scale   <= cfg_wdata[23:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_pairs.push_back(compensate(in_pressure_raw, in_temperature_raw));
      if (out_valid && out_ready) begin
        if (expected_pairs.size() == 0) begin
          $error("unexpected result transaction");
          errs = errs + 1;
        end else begin
          want = expected_pairs.pop_front();
          if (want.pres !== out_pressure_comp) begin
            $error("pressure_comp expected %0d actual %0d", want.pres, out_pressure_comp);
            errs = errs + 1;
          end
          if (want.temp !== out_temperature_comp) begin
            $error("temperature_comp expected %0d actual %0d",
                   want.temp, out_temperature_comp);
            errs = errs + 1;
          end
        end
      end
      errors <= errors + errs;
    end
  end

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the barometric compensation core
// ----------------------------------------------------------------------------
// Runs the core through a sequence of coefficient and scale settings, from
// reset values through both extremes to random ones. Each setting gets a
// burst of raw pressure/temperature pairs; the scoreboard predicts and checks
// every result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import bsc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 700;
  localparam int PHASES = 7;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [RAW_W-1:0] in_pressure_raw;
  logic signed [RAW_W-1:0] in_temperature_raw;
  logic out_valid;
  logic out_ready;
  logic signed [PRES_W-1:0] out_pressure_comp;
  logic signed [TEMP_W-1:0] out_temperature_comp;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  int errors;
  int pending;
  int pairs_sent;
  int stall_cycles;
  bit calm;  // no idling on either side while set

  baro_sensor_compensation_core DUT (.*);

  baro_sensor_compensation_scoreboard scoreboard (
    .clk, .rst_n, .in_valid, .in_ready, .in_pressure_raw, .in_temperature_raw,
    .out_valid, .out_ready, .out_pressure_comp, .out_temperature_comp,
    .cfg_we, .cfg_index, .cfg_wdata, .errors, .pending
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // receiver side: unless calm is set, stalls at random, about 16 times in 100
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 16);
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("baro_sensor_compensation_core regression: fail");
        $finish;
      end
    end
  end

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // let the pipeline drain, then load a full coefficient set
  task automatic load_coefs(logic [23:0] tc, logic [39:0] pol, logic [63:0] pcc,
                            logic [15:0] c30, logic [23:0] ts, logic [23:0] ps);
    wait (pending == 0);
    repeat (TOT_LAT + 4) @(negedge clk);
    cfg_write(CFG_TEMP_COEFS, CFG_W'(tc));
    cfg_write(CFG_PRES_OFS_LIN, CFG_W'(pol));
    cfg_write(CFG_PRES_CROSS, pcc);
    cfg_write(CFG_PRES_CUBIC, CFG_W'(c30));
    cfg_write(CFG_TEMP_SCALE, CFG_W'(ts));
    cfg_write(CFG_PRES_SCALE, CFG_W'(ps));
    // out-of-range index must be ignored
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_IDX_W'($urandom_range(6, 7));
    cfg_wdata = {$urandom, $urandom};
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // one input transaction, with a random gap before it
  task automatic send_pair(logic [23:0] praw, logic [23:0] traw);
    if (!calm && $urandom_range(99) < 16) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_pressure_raw = praw;
    in_temperature_raw = traw;
    do @(posedge clk); while (!in_ready);
    pairs_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [23:0] rand_raw();
    case ($urandom_range(3))
      0: rand_raw = 24'($urandom);
      1: rand_raw = 24'($signed($urandom_range(0, 8000)) - 4000);
      2: rand_raw = 24'($urandom_range(0, 1) ? 24'h7fffff - $urandom_range(255)
                                             : 24'h800000 + $urandom_range(255));
      default: rand_raw = 24'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [23:0] rand_scale();
    case ($urandom_range(3))
      0: rand_scale = 24'($urandom_range(1, 24'hffffff));
      1: rand_scale = 24'($urandom_range(1, 16));
      default: rand_scale = 24'(1 << $urandom_range(17, 21));
    endcase
  endfunction

  initial begin
    logic [23:0] edge_vals[6];
    edge_vals = '{24'h800000, 24'h7fffff, 24'h000000, 24'hffffff, 24'h000001, 24'h800001};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pressure_raw = '0;
    in_temperature_raw = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    calm = 1'b0;
    pairs_sent = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // reset coefficients: everything zero, default scales
    for (int i = 0; i < 6; i++) send_pair(edge_vals[i], edge_vals[5 - i]);

    // all coefficients at their positive extreme, smallest scale
    load_coefs(24'h7ff7ff, {20'h7ffff, 20'h7ffff}, {4{16'h7fff}}, 16'h7fff,
               24'd1, 24'd1);
    for (int i = 0; i < 6; i++) send_pair(edge_vals[i], edge_vals[i]);

    // all coefficients at their negative extreme, largest scale
    load_coefs(24'h800800, {20'h80000, 20'h80000}, {4{16'h8000}}, 16'h8000,
               24'hffffff, 24'hffffff);
    for (int i = 0; i < 6; i++) send_pair(edge_vals[i], edge_vals[(i + 2) % 6]);

    // realistic scale with mixed-sign coefficients
    load_coefs(24'h0c8e1f, {20'h2f3a1, 20'hd4c21}, 64'h8123_7ffe_0042_ffb1, 16'hfe10,
               24'd524288, 24'd253952);
    for (int i = 0; i < 6; i++) send_pair(edge_vals[5 - i], edge_vals[i]);

    // random settings, each followed by a burst of random pairs
    for (int ph = 0; ph < PHASES; ph++) begin
      load_coefs(24'($urandom), 40'({$urandom, $urandom}), {$urandom, $urandom},
                 16'($urandom), rand_scale(), rand_scale());
      calm = (ph == 2);
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) send_pair(rand_raw(), rand_raw());
      calm = 1'b0;
    end
    in_valid = 1'b0;

    wait (pending == 0);
    repeat (TOT_LAT + 10) @(posedge clk);
    $display("sent %0d pressure/temperature pairs over %0d coefficient settings",
             pairs_sent, PHASES + 4);
    $display("coefficient and scale extremes, saturation, and random stalls covered");
    if (errors == 0) begin
      $display("baro_sensor_compensation_core regression: pass");
    end else begin
      $display("baro_sensor_compensation_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> baro_sensor_compensation_core.f
+incdir+rtl/core
rtl/core/bsc_pkg.sv
rtl/core/bsc_div.sv
rtl/core/bsc_poly.sv
rtl/core/baro_sensor_compensation_core.sv
rtl/core/bsc_checker.sv
sim/baro_sensor_compensation_scoreboard.sv
sim/tb.sv
